>>> sv/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants for the line editor: byte codes, register
// indexes, reset values and the controller state type.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int LineBytesDef = 32;
  localparam int DataW        = 8;
  localparam int CfgIndexW    = 1;

  localparam logic [CfgIndexW-1:0] RegDeleteCode = 1'b0;
  localparam logic [CfgIndexW-1:0] RegEscapeCode = 1'b1;

  localparam logic [DataW-1:0] DeleteReset = 8'd127;
  localparam logic [DataW-1:0] EscapeReset = 8'd27;

  localparam logic [DataW-1:0] CodeCr  = 8'h0D;
  localparam logic [DataW-1:0] CodeLf  = 8'h0A;
  localparam logic [DataW-1:0] CodeBs  = 8'h08;
  localparam logic [DataW-1:0] CodeSp  = 8'h20;
  localparam logic [DataW-1:0] CodeNul = 8'h00;

  typedef struct packed {
    logic [DataW-1:0] delete_code;
    logic [DataW-1:0] escape_code;
  } cle_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ECHO,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_TERM
  } ctrl_state_t;

endpackage

>>> sv/cle_rx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_rx_if
// Receive channel: one terminal byte per item.
// ----------------------------------------------------------------------------
interface cle_rx_if;
  logic                    valid;
  logic                    ready;
  logic [cle_pkg::DataW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> sv/cle_tx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_tx_if
// Result channel: echo bytes and completed line bytes.
// ----------------------------------------------------------------------------
interface cle_tx_if;
  logic                    valid;
  logic                    ready;
  logic                    channel;
  logic [cle_pkg::DataW-1:0] data_byte;
  logic                    end_of_line;
  logic                    last;

  modport source (output valid, output channel, output data_byte,
                  output end_of_line, output last, input ready);
  modport sink   (input valid, input channel, input data_byte,
                  input end_of_line, input last, output ready);
endinterface

>>> sv/cle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter  int WIDTH = cle_pkg::DataW,
  parameter  int DEPTH = cle_pkg::LineBytesDef,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/cle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ctrl
// Byte decode, fill position, echo sequencing, line read-out from the store
// and the output register.
// ----------------------------------------------------------------------------
module cle_ctrl #(
  parameter  int LINE_BYTES = cle_pkg::LineBytesDef,
  localparam int AW         = $clog2(LINE_BYTES)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cle_pkg::cle_cfg_t         cfg,
  cle_rx_if.sink                    rx,
  cle_tx_if.source                  tx,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [cle_pkg::DataW-1:0] mem_wdata,
  output logic                      mem_re,
  output logic [AW-1:0]             mem_raddr,
  input  logic [cle_pkg::DataW-1:0] mem_rdata
);

  localparam logic [AW-1:0] PosMax = AW'(LINE_BYTES - 1);

  cle_pkg::ctrl_state_t state, state_next;

  logic [AW-1:0] pos;
  logic [AW-1:0] rd_idx;
  logic          echo_step;
  logic          eol_kind;

  logic                      out_valid;
  logic                      out_channel;
  logic [cle_pkg::DataW-1:0] out_byte;
  logic                      out_eol;
  logic                      out_last;

  logic                      ld;
  logic                      ld_channel;
  logic [cle_pkg::DataW-1:0] ld_byte;
  logic                      ld_eol;
  logic                      ld_last;

  logic load_ok;
  logic accept;
  logic is_eol;
  logic is_esc;
  logic is_del;
  logic is_ord;
  logic rd_final;

  assign load_ok = !out_valid || tx.ready;
  assign rx.ready = (state == cle_pkg::ST_IDLE) && load_ok;
  assign accept = rx.valid && rx.ready;

  assign is_eol = (rx.rx_byte == cle_pkg::CodeCr) || (rx.rx_byte == cle_pkg::CodeLf);
  assign is_esc = !is_eol && (rx.rx_byte == cfg.escape_code);
  assign is_del = !is_eol && !is_esc &&
                  ((rx.rx_byte == cfg.delete_code) || (rx.rx_byte == cle_pkg::CodeBs));
  assign is_ord = !is_eol && !is_esc && !is_del && (pos < PosMax);

  assign rd_final = ((AW+1)'(rd_idx) + (AW+1)'(1)) == (AW+1)'(pos);

  assign mem_waddr = pos;
  assign mem_wdata = rx.rx_byte;
  assign mem_raddr = rd_idx;

  assign tx.valid       = out_valid;
  assign tx.channel     = out_channel;
  assign tx.data_byte   = out_byte;
  assign tx.end_of_line = out_eol;
  assign tx.last        = out_last;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cle_pkg::ST_IDLE: begin
        if (accept && (is_eol || is_del)) begin
          state_next = cle_pkg::ST_ECHO;
        end
      end
      cle_pkg::ST_ECHO: begin
        if (load_ok) begin
          if (eol_kind) begin
            state_next = (pos == '0) ? cle_pkg::ST_TERM : cle_pkg::ST_RD_ADDR;
          end else if (echo_step) begin
            state_next = cle_pkg::ST_IDLE;
          end
        end
      end
      cle_pkg::ST_RD_ADDR: begin
        state_next = cle_pkg::ST_RD_DATA;
      end
      cle_pkg::ST_RD_DATA: begin
        if (load_ok) begin
          state_next = rd_final ? cle_pkg::ST_TERM : cle_pkg::ST_RD_ADDR;
        end
      end
      cle_pkg::ST_TERM: begin
        if (load_ok) begin
          state_next = cle_pkg::ST_IDLE;
        end
      end
      default: state_next = cle_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ld         = 1'b0;
    ld_channel = 1'b0;
    ld_byte    = cle_pkg::CodeNul;
    ld_eol     = 1'b0;
    ld_last    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    unique case (state)
      cle_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (is_eol) begin
            ld      = 1'b1;
            ld_byte = cle_pkg::CodeCr;
          end else if (is_del) begin
            ld      = 1'b1;
            ld_byte = cle_pkg::CodeBs;
          end else if (is_ord) begin
            ld      = 1'b1;
            ld_byte = rx.rx_byte;
            ld_last = 1'b1;
            mem_we  = 1'b1;
          end
        end
      end
      cle_pkg::ST_ECHO: begin
        if (load_ok) begin
          ld = 1'b1;
          if (eol_kind) begin
            ld_byte = cle_pkg::CodeLf;
          end else if (echo_step) begin
            ld_byte = cle_pkg::CodeBs;
            ld_last = 1'b1;
          end else begin
            ld_byte = cle_pkg::CodeSp;
          end
        end
      end
      cle_pkg::ST_RD_ADDR: begin
        mem_re = 1'b1;
      end
      cle_pkg::ST_RD_DATA: begin
        if (load_ok) begin
          ld         = 1'b1;
          ld_channel = 1'b1;
          ld_byte    = mem_rdata;
        end
      end
      cle_pkg::ST_TERM: begin
        if (load_ok) begin
          ld         = 1'b1;
          ld_channel = 1'b1;
          ld_eol     = 1'b1;
          ld_last    = 1'b1;
        end
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cle_pkg::ST_IDLE;
      pos       <= '0;
      rd_idx    <= '0;
      echo_step <= 1'b0;
      eol_kind  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ld) begin
        out_valid <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        echo_step <= 1'b0;
        eol_kind  <= is_eol;
        if (is_del && (pos != '0)) begin
          pos <= pos - AW'(1);
        end else if (is_ord) begin
          pos <= pos + AW'(1);
        end
      end
      if ((state == cle_pkg::ST_ECHO) && load_ok) begin
        echo_step <= 1'b1;
        rd_idx    <= '0;
      end
      if ((state == cle_pkg::ST_RD_DATA) && load_ok) begin
        rd_idx <= rd_idx + AW'(1);
      end
      if ((state == cle_pkg::ST_TERM) && load_ok) begin
        pos <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_channel <= ld_channel;
      out_byte    <= ld_byte;
      out_eol     <= ld_eol;
      out_last    <= ld_last;
    end
  end

  a_mem_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("store read and write in the same cycle");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= PosMax)
    else $error("fill position beyond store");

  a_read_below_fill: assert property (@(posedge clk) disable iff (rst)
    (state == cle_pkg::ST_RD_DATA) |-> (rd_idx < pos))
    else $error("line read past fill position");

  a_eol_echo: assert property (@(posedge clk) disable iff (rst)
    (accept && is_eol) |=> (tx.valid && !tx.channel && (tx.data_byte == cle_pkg::CodeCr)))
    else $error("end of line not echoed with CR");

  a_term_shape: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.end_of_line) |->
      (tx.channel && tx.last && (tx.data_byte == cle_pkg::CodeNul)))
    else $error("malformed line terminator");

endmodule

>>> sv/cli_line_editor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_line_editor_core
// Terminal line editor with echo: stores typed bytes, handles delete and
// backspace, and on CR or LF hands out the stored line with a terminator.
// ----------------------------------------------------------------------------
// Echo: output starts in the cycle after a byte is accepted; an escape or
//   a byte with the store full gives none. Delete echoes BS, SP, BS; end of
//   line echoes CR, LF, then one store read and one output load per stored
//   byte via the single read port, then the terminator; rx waits for idle.
// Reset: synchronous; clears the fill position, output valid and state, and
//   loads the delete and escape codes with 127 and 27. Store is not cleared.
module cli_line_editor_core #(
  parameter int LINE_BYTES = cle_pkg::LineBytesDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cle_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [cle_pkg::DataW-1:0]     cfg_data,
  cle_rx_if.sink                        rx,
  cle_tx_if.source                      tx
);

  localparam int AW = $clog2(LINE_BYTES);

  cle_pkg::cle_cfg_t cfg;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [cle_pkg::DataW-1:0] mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [cle_pkg::DataW-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delete_code <= cle_pkg::DeleteReset;
      cfg.escape_code <= cle_pkg::EscapeReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cle_pkg::RegDeleteCode: cfg.delete_code <= cfg_data;
        cle_pkg::RegEscapeCode: cfg.escape_code <= cfg_data;
      endcase
    end
  end

  cle_ctrl #(
    .LINE_BYTES (LINE_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rx        (rx),
    .tx        (tx),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  cle_ram #(
    .WIDTH (cle_pkg::DataW),
    .DEPTH (LINE_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
